@@ rtl/core/bleadv_pkg.sv @@
// Package for the advertising payload aggregator: field widths, status and
// register codes, fixed advertising bytes, and the controller/datapath structs.
// Has no dependencies; every other file in rtl/core refers to it by scoped name.
package bleadv_pkg;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_NAME_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_CHARS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_TYPE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPANY_ID  = 2'd3;

  // Field widths fixed by the interface.
  localparam int unsigned NAME_LEN_W     = 4;
  localparam int unsigned NAME_CHARS_W   = 64;
  localparam int unsigned NAME_MAX_CHARS = 8;
  localparam int unsigned DEV_TYPE_W     = 8;
  localparam int unsigned COMPANY_ID_W   = 16;
  localparam int unsigned MSG_TYPE_W     = 8;
  localparam int unsigned MSG_LEN_W      = 4;
  localparam int unsigned MSG_DATA_W     = 56;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned BYTE_W         = 8;

  // Byte position inside one message (type byte plus up to seven data bytes).
  localparam int unsigned BYTE_IDX_W = 3;
  // Byte position inside the fixed header (two name AD bytes, up to eight
  // characters, five manufacturer header bytes).
  localparam int unsigned HDR_IDX_W  = 4;

  // Bytes in the header that do not depend on the name characters:
  // name length, name AD type, manufacturer length, manufacturer AD type,
  // company low, company high, device type.
  localparam int unsigned HDR_FIXED_BYTES = 7;

  localparam logic [COMPANY_ID_W-1:0] COMPANY_ID_RESET = 16'h0B16;

  localparam logic [BYTE_W-1:0] AD_TYPE_NAME  = 8'h09;
  localparam logic [BYTE_W-1:0] AD_TYPE_MANUF = 8'hFF;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STS_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STS_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] STS_BYTE     = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic enq;          // store the incoming message or note that the queue is full
    logic build_empty;  // note an empty-queue response
    logic build;        // start the fit scan at the queue head
    logic resp_load;    // place the single response in the output register
    logic scan_step;    // take the scanned message into the payload
    logic hdr_start;    // rewind to the head and start the header bytes
    logic emit_hdr;     // send one header byte
    logic emit_msg;     // send one message byte
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_ready;    // the output register can take a new result
    logic q_empty;      // no messages queued
    logic scan_go;      // the scanned message fits and is present
    logic hdr_end;      // current header byte is the final one
    logic take_zero;    // no messages were taken into the payload
    logic msg_end;      // current message byte is the final one of its message
    logic take_one;     // the current message is the final one taken
  } sts_t;

endpackage

@@ rtl/core/ble_adv_payload_aggregator_unit.sv @@
// Top level of the advertising payload aggregator: joins the controller and
// the datapath. Depends on bleadv_pkg, bleadv_ctrl and bleadv_dp.
//
// Usage. The input channel (in_valid_i / in_stall_o) carries one transaction
// per command: func_i = 0 queues a beacon message (msg_type_i, msg_length_i,
// msg_data_i), func_i = 1 builds one advertising payload from the queue. The
// output channel (out_valid_o / out_stall_i) returns results: one transaction
// with status accepted or full for an enqueue, one with status empty for a
// build on an empty queue, otherwise one payload byte per transaction with
// last_o marking the final byte. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i while the block is idle.
// A single-result command waits in the response state until the output
// register can take its result, then returns to idle, so the block takes
// no new command before that result is loaded.
// A build first runs the fit scan over the queue memory's single read port,
// taking queued messages into the payload in order until one does not fit or
// none is left, and closes with a step that rewinds to the head; it then sends
// one byte per cycle while the receiver does not stall, until the last byte.
// in_stall_o is high while a command is in progress. When the receiver stalls,
// the result is held in the output register and byte emission pauses.
// Reset empties the queue and returns the registers to their default values.
module ble_adv_payload_aggregator_unit #(
  parameter int unsigned QUEUE_DEPTH    = 8,
  parameter int unsigned PAYLOAD_MAX    = 31,
  parameter int unsigned MAX_DATA_BYTES = 7
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bleadv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bleadv_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic [bleadv_pkg::MSG_TYPE_W-1:0] msg_type_i,
  input  logic [bleadv_pkg::MSG_LEN_W-1:0]  msg_length_i,
  input  logic [bleadv_pkg::MSG_DATA_W-1:0] msg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bleadv_pkg::STATUS_W-1:0]   status_o,
  output logic [bleadv_pkg::BYTE_W-1:0]     payload_byte_o,
  output logic                              last_o
);

  // Command and status between the sequencer and the datapath.
  bleadv_pkg::cmd_t cmd;
  bleadv_pkg::sts_t sts;

  // The controller decides what happens each cycle; it accepts a command
  // only in its idle state.
  bleadv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath owns the queue memory, the configuration registers and
  // the output register that decouples the block from the receiver.
  bleadv_dp #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .PAYLOAD_MAX    (PAYLOAD_MAX),
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .msg_type_i     (msg_type_i),
    .msg_length_i   (msg_length_i),
    .msg_data_i     (msg_data_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .payload_byte_o (payload_byte_o),
    .last_o         (last_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

@@ rtl/core/bleadv_ctrl.sv @@
// Controller of the advertising payload aggregator: sequences enqueue,
// fit scan, header emission and message emission.
// Depends on bleadv_pkg for the command and status structs.
module bleadv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              func_i,
  output logic              in_stall_o,
  input  bleadv_pkg::sts_t  sts_i,
  output bleadv_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RESP = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_HDR  = 3'd3;
  localparam logic [2:0] ST_MSG  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!func_i) begin
            cmd_o.enq = 1'b1;
            state_d   = ST_RESP;
          end else if (sts_i.q_empty) begin
            cmd_o.build_empty = 1'b1;
            state_d           = ST_RESP;
          end else begin
            cmd_o.build = 1'b1;
            state_d     = ST_SCAN;
          end
        end
      end
      ST_RESP: begin
        if (sts_i.out_ready) begin
          cmd_o.resp_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_go) begin
          cmd_o.scan_step = 1'b1;
        end else begin
          cmd_o.hdr_start = 1'b1;
          state_d         = ST_HDR;
        end
      end
      ST_HDR: begin
        if (sts_i.out_ready) begin
          cmd_o.emit_hdr = 1'b1;
          if (sts_i.hdr_end) begin
            state_d = sts_i.take_zero ? ST_IDLE : ST_MSG;
          end
        end
      end
      ST_MSG: begin
        if (sts_i.out_ready) begin
          cmd_o.emit_msg = 1'b1;
          if (sts_i.msg_end && sts_i.take_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

@@ rtl/core/bleadv_dp.sv @@
// Datapath of the advertising payload aggregator: configuration registers,
// message queue memory with pointers, payload byte selection and output register.
// Depends on bleadv_pkg; driven by commands from bleadv_ctrl.
module bleadv_dp #(
  parameter int unsigned QUEUE_DEPTH    = 8,
  parameter int unsigned PAYLOAD_MAX    = 31,
  parameter int unsigned MAX_DATA_BYTES = 7
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [bleadv_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bleadv_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [bleadv_pkg::MSG_TYPE_W-1:0]     msg_type_i,
  input  logic [bleadv_pkg::MSG_LEN_W-1:0]      msg_length_i,
  input  logic [bleadv_pkg::MSG_DATA_W-1:0]     msg_data_i,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output logic [bleadv_pkg::STATUS_W-1:0]       status_o,
  output logic [bleadv_pkg::BYTE_W-1:0]         payload_byte_o,
  output logic                                  last_o,
  input  bleadv_pkg::cmd_t                      cmd_i,
  output bleadv_pkg::sts_t                      sts_o
);

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned N_W    = $clog2(PAYLOAD_MAX + MAX_DATA_BYTES + 2);
  localparam int unsigned DATA_W = 8 * MAX_DATA_BYTES;
  localparam int unsigned LEN_W  = bleadv_pkg::MSG_LEN_W;

  // Configuration registers.
  logic [bleadv_pkg::NAME_LEN_W-1:0]   name_len_q;
  logic [bleadv_pkg::NAME_CHARS_W-1:0] name_chars_q;
  logic [bleadv_pkg::DEV_TYPE_W-1:0]   dev_type_q;
  logic [bleadv_pkg::COMPANY_ID_W-1:0] company_id_q;
  logic [bleadv_pkg::NAME_LEN_W-1:0]   name_len_wr;

  // Queue storage and read port.
  logic [bleadv_pkg::MSG_TYPE_W-1:0] slot_type_mem [QUEUE_DEPTH];
  logic [LEN_W-1:0]                  slot_len_mem  [QUEUE_DEPTH];
  logic [DATA_W-1:0]                 slot_data_mem [QUEUE_DEPTH];
  logic [bleadv_pkg::MSG_TYPE_W-1:0] rd_type_q;
  logic [LEN_W-1:0]                  rd_len_q;
  logic [DATA_W-1:0]                 rd_data_q;

  // Queue pointers and build bookkeeping.
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] scan_left_q, scan_left_d;
  logic [CNT_W-1:0] take_q, take_d;
  logic [N_W-1:0]   n_run_q, n_run_d;
  logic [bleadv_pkg::HDR_IDX_W-1:0]  hdr_idx_q, hdr_idx_d;
  logic [bleadv_pkg::BYTE_IDX_W-1:0] byte_idx_q, byte_idx_d;
  logic [bleadv_pkg::STATUS_W-1:0]   resp_q, resp_d;

  // Output register.
  logic                            out_valid_q;
  logic [bleadv_pkg::STATUS_W-1:0] out_status_q;
  logic [bleadv_pkg::BYTE_W-1:0]   out_byte_q;
  logic                            out_last_q;

  logic                          q_full;
  logic [LEN_W-1:0]              len_sat;
  logic                          fits;
  logic [bleadv_pkg::HDR_IDX_W-1:0] name_end;
  logic [bleadv_pkg::HDR_IDX_W-1:0] hdr_rel;
  logic [bleadv_pkg::BYTE_W-1:0] hdr_byte;
  logic [bleadv_pkg::BYTE_W-1:0] msg_byte;
  logic [bleadv_pkg::BYTE_W-1:0] mlen_byte;
  logic                          hdr_end;
  logic                          msg_end;
  logic                          out_ready;
  logic                          out_load;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  always_comb begin
    name_len_wr = cfg_wdata_i[bleadv_pkg::NAME_LEN_W-1:0];
    if (name_len_wr > bleadv_pkg::NAME_LEN_W'(bleadv_pkg::NAME_MAX_CHARS)) begin
      name_len_wr = bleadv_pkg::NAME_LEN_W'(bleadv_pkg::NAME_MAX_CHARS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_len_q   <= '0;
      name_chars_q <= '0;
      dev_type_q   <= '0;
      company_id_q <= bleadv_pkg::COMPANY_ID_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bleadv_pkg::CFG_NAME_LENGTH: name_len_q <= name_len_wr;
        bleadv_pkg::CFG_NAME_CHARS:  name_chars_q <= cfg_wdata_i;
        bleadv_pkg::CFG_DEVICE_TYPE: dev_type_q <= cfg_wdata_i[bleadv_pkg::DEV_TYPE_W-1:0];
        bleadv_pkg::CFG_COMPANY_ID:  company_id_q <= cfg_wdata_i[bleadv_pkg::COMPANY_ID_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Queue memory: written at the tail on enqueue, read at the next pointer.
  // The read data therefore always belongs to the entry at ptr_q.
  // ---------------------------------------------------------------------------
  assign q_full = (count_q == CNT_W'(QUEUE_DEPTH));

  always_comb begin
    len_sat = msg_length_i;
    if (len_sat == '0) begin
      len_sat = LEN_W'(1);
    end else if (len_sat > LEN_W'(MAX_DATA_BYTES + 1)) begin
      len_sat = LEN_W'(MAX_DATA_BYTES + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.enq && !q_full) begin
      slot_type_mem[tail_q] <= msg_type_i;
      slot_len_mem[tail_q]  <= len_sat;
      slot_data_mem[tail_q] <= msg_data_i[DATA_W-1:0];
    end
    rd_type_q <= slot_type_mem[ptr_d];
    rd_len_q  <= slot_len_mem[ptr_d];
    rd_data_q <= slot_data_mem[ptr_d];
  end

  // ---------------------------------------------------------------------------
  // Byte selection.
  // ---------------------------------------------------------------------------
  assign fits = ((n_run_q + N_W'(rd_len_q)) < N_W'(PAYLOAD_MAX));

  assign name_end  = bleadv_pkg::HDR_IDX_W'(name_len_q) + bleadv_pkg::HDR_IDX_W'(2);
  assign hdr_rel   = hdr_idx_q - name_end;
  assign hdr_end   = (hdr_idx_q == name_end + bleadv_pkg::HDR_IDX_W'(4));
  // Manufacturer length is four plus the lengths taken, which is the running
  // payload size less the name structure and the leading length byte.
  assign mlen_byte = 8'(n_run_q) - 8'(name_len_q) - 8'd3;

  always_comb begin
    hdr_byte = dev_type_q;
    if (hdr_idx_q == '0) begin
      hdr_byte = 8'(name_len_q) + 8'd1;
    end else if (hdr_idx_q == bleadv_pkg::HDR_IDX_W'(1)) begin
      hdr_byte = bleadv_pkg::AD_TYPE_NAME;
    end else if (hdr_idx_q < name_end) begin
      hdr_byte = name_chars_q[8 * 3'(hdr_idx_q - bleadv_pkg::HDR_IDX_W'(2)) +: 8];
    end else begin
      unique case (hdr_rel)
        4'd0:    hdr_byte = mlen_byte;
        4'd1:    hdr_byte = bleadv_pkg::AD_TYPE_MANUF;
        4'd2:    hdr_byte = company_id_q[7:0];
        4'd3:    hdr_byte = company_id_q[15:8];
        default: hdr_byte = dev_type_q;
      endcase
    end
  end

  assign msg_end = (byte_idx_q == bleadv_pkg::BYTE_IDX_W'(rd_len_q - LEN_W'(1)));

  always_comb begin
    msg_byte = rd_type_q;
    for (int k = 0; k < MAX_DATA_BYTES; k++) begin
      if (byte_idx_q == bleadv_pkg::BYTE_IDX_W'(k + 1)) begin
        msg_byte = rd_data_q[8 * k +: 8];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pointer and counter updates.
  // ---------------------------------------------------------------------------
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    scan_left_d = scan_left_q;
    take_d      = take_q;
    n_run_d     = n_run_q;
    hdr_idx_d   = hdr_idx_q;
    byte_idx_d  = byte_idx_q;
    resp_d      = resp_q;

    if (cmd_i.enq) begin
      if (q_full) begin
        resp_d = bleadv_pkg::STS_FULL;
      end else begin
        resp_d  = bleadv_pkg::STS_ACCEPTED;
        tail_d  = wrap_inc(tail_q);
        count_d = count_q + CNT_W'(1);
      end
    end
    if (cmd_i.build_empty) begin
      resp_d = bleadv_pkg::STS_EMPTY;
    end
    if (cmd_i.build) begin
      ptr_d       = head_q;
      scan_left_d = count_q;
      take_d      = '0;
      n_run_d     = N_W'(name_len_q) + N_W'(bleadv_pkg::HDR_FIXED_BYTES);
    end
    if (cmd_i.scan_step) begin
      ptr_d       = wrap_inc(ptr_q);
      scan_left_d = scan_left_q - CNT_W'(1);
      take_d      = take_q + CNT_W'(1);
      n_run_d     = n_run_q + N_W'(rd_len_q);
    end
    if (cmd_i.hdr_start) begin
      ptr_d      = head_q;
      hdr_idx_d  = '0;
      byte_idx_d = '0;
    end
    if (cmd_i.emit_hdr) begin
      hdr_idx_d = hdr_idx_q + bleadv_pkg::HDR_IDX_W'(1);
    end
    if (cmd_i.emit_msg) begin
      if (msg_end) begin
        byte_idx_d = '0;
        ptr_d      = wrap_inc(ptr_q);
        head_d     = wrap_inc(head_q);
        count_d    = count_q - CNT_W'(1);
        take_d     = take_q - CNT_W'(1);
      end else begin
        byte_idx_d = byte_idx_q + bleadv_pkg::BYTE_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      ptr_q       <= '0;
      scan_left_q <= '0;
      take_q      <= '0;
      n_run_q     <= '0;
      hdr_idx_q   <= '0;
      byte_idx_q  <= '0;
      resp_q      <= bleadv_pkg::STS_ACCEPTED;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      scan_left_q <= scan_left_d;
      take_q      <= take_d;
      n_run_q     <= n_run_d;
      hdr_idx_q   <= hdr_idx_d;
      byte_idx_q  <= byte_idx_d;
      resp_q      <= resp_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  assign out_ready = !out_valid_q || !out_stall_i;
  assign out_load  = cmd_i.resp_load || cmd_i.emit_hdr || cmd_i.emit_msg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_load) begin
      out_status_q <= resp_q;
      out_byte_q   <= '0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.emit_hdr) begin
      out_status_q <= bleadv_pkg::STS_BYTE;
      out_byte_q   <= hdr_byte;
      out_last_q   <= hdr_end && (take_q == '0);
    end else if (cmd_i.emit_msg) begin
      out_status_q <= bleadv_pkg::STS_BYTE;
      out_byte_q   <= msg_byte;
      out_last_q   <= msg_end && (take_q == CNT_W'(1));
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign payload_byte_o = out_byte_q;
  assign last_o         = out_last_q;

  assign sts_o.out_ready = out_ready;
  assign sts_o.q_empty   = (count_q == '0);
  assign sts_o.scan_go   = (scan_left_q != '0) && fits;
  assign sts_o.hdr_end   = hdr_end;
  assign sts_o.take_zero = (take_q == '0);
  assign sts_o.msg_end   = msg_end;
  assign sts_o.take_one  = (take_q == CNT_W'(1));

endmodule

@@ rtl/core/bleadv_chk.sv @@
// Port-level checker for the advertising payload aggregator and its bind.
// Depends on bleadv_pkg; attaches to ble_adv_payload_aggregator_unit.
module bleadv_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [bleadv_pkg::STATUS_W-1:0] status_o,
  input logic [bleadv_pkg::BYTE_W-1:0]   payload_byte_o,
  input logic                            last_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(payload_byte_o) && $stable(last_o))
    else $error("stalled result changed");

  // Responses other than payload bytes are single transactions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != bleadv_pkg::STS_BYTE) |-> last_o)
    else $error("response without last");

  // Responses other than payload bytes carry a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != bleadv_pkg::STS_BYTE) |-> (payload_byte_o == '0))
    else $error("response with nonzero byte");

  // An accepted command makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block not busy after acceptance");

endmodule

bind ble_adv_payload_aggregator_unit bleadv_chk u_bleadv_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .payload_byte_o (payload_byte_o),
  .last_o         (last_o)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for ble_adv_payload_aggregator_unit: random and directed
// enqueue/build traffic, a scoreboard that predicts every result. Needs bleadv_pkg.
module testbench;
  import bleadv_pkg::*;

  localparam int unsigned QUEUE_DEPTH    = 8;
  localparam int unsigned PAYLOAD_MAX    = 31;
  localparam int unsigned MAX_DATA_BYTES = 7;

  localparam logic FUNC_ENQUEUE = 1'b0;
  localparam logic FUNC_BUILD   = 1'b1;

  localparam int unsigned LONG_HOLD      = 150;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned PHASE_ITEMS    = 48;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   data;
    logic                last;
  } adv_result_t;

  // Mirrors the message queue and the registers and keeps the results that
  // the block still owes, oldest first.
  class payload_scoreboard;
    logic [MSG_TYPE_W-1:0] slot_kind  [QUEUE_DEPTH];
    logic [MSG_LEN_W-1:0]  slot_len   [QUEUE_DEPTH];
    logic [MSG_DATA_W-1:0] slot_bytes [QUEUE_DEPTH];
    int unsigned head_ptr, tail_ptr, fill;
    int unsigned name_len;
    logic [NAME_CHARS_W-1:0] name_text;
    logic [DEV_TYPE_W-1:0]   dev_type;
    logic [COMPANY_ID_W-1:0] company;
    adv_result_t pending_results[$];
    int unsigned errors, checked, payloads, full_hits, empty_hits;

    function new();
      head_ptr   = 0;
      tail_ptr   = 0;
      fill       = 0;
      name_len   = 0;
      name_text  = '0;
      dev_type   = '0;
      company    = COMPANY_ID_RESET;
      errors     = 0;
      checked    = 0;
      payloads   = 0;
      full_hits  = 0;
      empty_hits = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_NAME_LENGTH: name_len = (value[3:0] > NAME_MAX_CHARS) ? NAME_MAX_CHARS : value[3:0];
        CFG_NAME_CHARS:  name_text = value;
        CFG_DEVICE_TYPE: dev_type = value[DEV_TYPE_W-1:0];
        CFG_COMPANY_ID:  company = value[COMPANY_ID_W-1:0];
        default: ;
      endcase
    endfunction

    function void owe(logic [STATUS_W-1:0] st, logic [BYTE_W-1:0] b, logic l);
      adv_result_t r;
      r.status = st;
      r.data   = b;
      r.last   = l;
      pending_results.push_back(r);
    endfunction

    // Applies one accepted transaction to the mirrored state and queues the
    // results it must produce.
    function void note_command(logic func, logic [MSG_TYPE_W-1:0] kind,
                               logic [MSG_LEN_W-1:0] len, logic [MSG_DATA_W-1:0] bytes);
      logic [BYTE_W-1:0] frame[$];
      logic [MSG_DATA_W-1:0] rest;
      int unsigned clipped, manuf_pos, manuf_len, i;
      bit fits;
      if (func == FUNC_ENQUEUE) begin
        clipped = (len == 0) ? 1 : (len > MAX_DATA_BYTES + 1) ? MAX_DATA_BYTES + 1 : len;
        if (fill >= QUEUE_DEPTH) begin
          owe(STS_FULL, '0, 1'b1);
          full_hits++;
        end else begin
          slot_kind[tail_ptr]  = kind;
          slot_len[tail_ptr]   = clipped[MSG_LEN_W-1:0];
          slot_bytes[tail_ptr] = bytes;
          tail_ptr = (tail_ptr + 1) % QUEUE_DEPTH;
          fill++;
          owe(STS_ACCEPTED, '0, 1'b1);
        end
      end else if (fill == 0) begin
        owe(STS_EMPTY, '0, 1'b1);
        empty_hits++;
      end else begin
        // Local name structure, then the manufacturer header whose length
        // byte is patched once the taken messages are known.
        frame.push_back(8'(name_len + 1));
        frame.push_back(AD_TYPE_NAME);
        for (i = 0; i < name_len; i++) frame.push_back(name_text[8*i +: 8]);
        manuf_pos = frame.size();
        frame.push_back(8'h00);
        frame.push_back(AD_TYPE_MANUF);
        frame.push_back(company[7:0]);
        frame.push_back(company[15:8]);
        frame.push_back(dev_type);
        manuf_len = 4;
        fits = 1'b1;
        while (fill > 0 && fits) begin
          if (frame.size() + slot_len[head_ptr] >= PAYLOAD_MAX) begin
            fits = 1'b0;
          end else begin
            frame.push_back(slot_kind[head_ptr]);
            rest = slot_bytes[head_ptr];
            for (i = 1; i < slot_len[head_ptr]; i++) begin
              frame.push_back(rest[7:0]);
              rest = rest >> 8;
            end
            manuf_len += slot_len[head_ptr];
            head_ptr = (head_ptr + 1) % QUEUE_DEPTH;
            fill--;
          end
        end
        frame[manuf_pos] = 8'(manuf_len);
        foreach (frame[k]) owe(STS_BYTE, frame[k], k == frame.size() - 1);
        payloads++;
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [BYTE_W-1:0] b, logic l);
      adv_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d byte 0x%02h last %0b", $time, st, b, l);
        errors++;
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (st !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, st);
          errors++;
        end
        if (b !== want.data) begin
          $display("%0t: payload byte mismatch, expected 0x%02h, actual 0x%02h",
                   $time, want.data, b);
          errors++;
        end
        if (l !== want.last) begin
          $display("%0t: last flag mismatch, expected %0b, actual %0b", $time, want.last, l);
          errors++;
        end
      end
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  func_i;
  logic [MSG_TYPE_W-1:0] msg_type_i;
  logic [MSG_LEN_W-1:0]  msg_length_i;
  logic [MSG_DATA_W-1:0] msg_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [STATUS_W-1:0]   status_o;
  logic [BYTE_W-1:0]     payload_byte_o;
  logic                  last_o;

  payload_scoreboard sb;

  // Flags shared between the sender and the receiver processes, and run counters.
  bit          quiet = 1'b0;         // no idling on either side
  bit          hold_request = 1'b0;  // receiver should do its long hold once
  bit          hold_done = 1'b0;
  int unsigned commands_sent = 0;
  int unsigned settings_used = 1;
  int unsigned idle_cycles = 0;

  ble_adv_payload_aggregator_unit #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PAYLOAD_MAX   (PAYLOAD_MAX),
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .msg_type_i    (msg_type_i),
    .msg_length_i  (msg_length_i),
    .msg_data_i    (msg_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .payload_byte_o(payload_byte_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offers one transaction from a falling edge and returns at the falling edge
  // after it was taken, possibly after an idle gap with valid low.
  task automatic issue_command(input logic func, input logic [MSG_TYPE_W-1:0] kind,
                               input logic [MSG_LEN_W-1:0] len,
                               input logic [MSG_DATA_W-1:0] bytes);
    int unsigned gap;
    in_valid_i   <= 1'b1;
    func_i       <= func;
    msg_type_i   <= kind;
    msg_length_i <= len;
    msg_data_i   <= bytes;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_command(func, kind, len, bytes);
    commands_sent++;
    @(negedge clk_i);
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Most lengths are legal; some fall outside 1..8 to exercise the clamping.
  task automatic random_command(input int unsigned enq_share);
    logic func;
    logic [MSG_LEN_W-1:0] len;
    func = ($urandom_range(0, 99) < enq_share) ? FUNC_ENQUEUE : FUNC_BUILD;
    len  = ($urandom_range(0, 4) == 0) ? MSG_LEN_W'($urandom_range(0, 15))
                                       : MSG_LEN_W'($urandom_range(1, 8));
    issue_command(func, MSG_TYPE_W'($urandom_range(0, 255)), len,
                  56'({$urandom(), $urandom()}));
  endtask

  // Waits until every owed result has arrived, then lets the block return
  // to idle; called at a falling edge.
  task automatic drain_results();
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes all four registers on consecutive cycles; write enable stays high
  // across the burst and drops once at its end.
  task automatic load_settings(input logic [CFG_DATA_W-1:0] nlen, input logic [CFG_DATA_W-1:0] chars,
                               input logic [CFG_DATA_W-1:0] dev, input logic [CFG_DATA_W-1:0] comp);
    logic [CFG_DATA_W-1:0] vals [4];
    vals[CFG_NAME_LENGTH] = nlen;
    vals[CFG_NAME_CHARS]  = chars;
    vals[CFG_DEVICE_TYPE] = dev;
    vals[CFG_COMPANY_ID]  = comp;
    for (int r = 0; r < 4; r++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_IDX_W'(r);
      cfg_wdata_i <= vals[r];
      @(posedge clk_i);
      sb.set_register(CFG_IDX_W'(r), vals[r]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int unsigned enq_share [4];
    enq_share = '{70, 85, 60, 75};
    sb = new();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    func_i       = FUNC_ENQUEUE;
    msg_type_i   = '0;
    msg_length_i = '0;
    msg_data_i   = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Default registers: empty build with junk in the ignored fields, a zero
    // length and an oversized length, then fill the queue and overflow it.
    issue_command(FUNC_BUILD, 8'hA5, 4'hF, '1);
    issue_command(FUNC_ENQUEUE, 8'h00, 4'h0, '0);
    issue_command(FUNC_ENQUEUE, 8'hFF, 4'hF, '1);
    for (int k = 2; k <= 7; k++)
      issue_command(FUNC_ENQUEUE, MSG_TYPE_W'($urandom_range(0, 255)), MSG_LEN_W'(k),
                    56'({$urandom(), $urandom()}));
    issue_command(FUNC_ENQUEUE, 8'h3C, 4'h9, 56'({$urandom(), $urandom()}));
    // First build stops at a message that no longer fits, the second drains
    // the rest and the third finds the queue empty.
    repeat (3) issue_command(FUNC_BUILD, MSG_TYPE_W'($urandom_range(0, 255)),
                             MSG_LEN_W'($urandom_range(0, 15)),
                             56'({$urandom(), $urandom()}));
    in_valid_i <= 1'b0;

    // Oversized name length saturates to eight characters, all-ones fields.
    // A 23-byte payload cannot take an 8-byte message (would reach 31), but
    // a later 30-byte payload is just short enough.
    drain_results();
    load_settings(64'hF, '1, 64'hFF, 64'hFFFF);
    issue_command(FUNC_ENQUEUE, 8'h81, 4'h8, 56'({$urandom(), $urandom()}));
    issue_command(FUNC_ENQUEUE, 8'h42, 4'h8, 56'({$urandom(), $urandom()}));
    issue_command(FUNC_ENQUEUE, 8'h18, 4'h7, 56'({$urandom(), $urandom()}));
    repeat (3) issue_command(FUNC_BUILD, '0, '0, '0);
    in_valid_i <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      drain_results();
      case (p)
        0: load_settings(CFG_DATA_W'($urandom_range(0, 8)), {$urandom(), $urandom()},
                         CFG_DATA_W'($urandom_range(0, 255)),
                         CFG_DATA_W'($urandom_range(0, 65535)));
        1: load_settings('0, '0, '0, '0);
        2: load_settings(CFG_DATA_W'($urandom_range(9, 15)), {$urandom(), $urandom()},
                         64'hFF, 64'hFFFF);
        default: load_settings(CFG_DATA_W'($urandom_range(0, 8)), {$urandom(), $urandom()},
                               CFG_DATA_W'($urandom_range(0, 255)),
                               CFG_DATA_W'($urandom_range(0, 65535)));
      endcase
      quiet        = (p == 1);
      hold_request = (p == 0);
      repeat (PHASE_ITEMS) random_command(enq_share[p]);
      in_valid_i <= 1'b0;
    end

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d commands under %0d register settings: %0d payloads built,",
             commands_sent, settings_used, sb.payloads);
    $display("%0d queue-full and %0d queue-empty responses, %0d results checked.",
             sb.full_hits, sb.empty_hits, sb.checked);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Result side: checks each accepted transaction, then stalls for a random
  // number of cycles. Once per run it holds off long enough for the block to
  // back up and stall its input while the sender keeps offering.
  initial begin : result_sink
    int unsigned wait_cycles;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(status_o, payload_byte_o, last_o);
        @(negedge clk_i);
        wait_cycles = quiet ? 0 : $urandom_range(0, 5);
        if (hold_request && !hold_done) begin
          wait_cycles = LONG_HOLD;
          hold_done   = 1'b1;
        end
        if (wait_cycles > 0) begin
          out_stall_i <= 1'b1;
          repeat (wait_cycles) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transaction", idle_cycles);
      $display("testbench failed");
      $finish;
    end
  end

endmodule
